[hw/rtl/jsu_pkg.sv]
// Shared types for the JSON string unescape block.
// Holds the command word passed from the decoder to the output serialiser.
// No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

    // Most output bytes one input byte can give: a four-byte UTF-8 sequence.
    localparam int CMD_BYTES = 4;
    localparam int CMD_IDX_W = 2;

    // One decoded command: up to four bytes, or a single end marker.
    typedef struct packed {
        logic [CMD_IDX_W-1:0]       last_idx;
        logic                       is_end;
        logic [CMD_BYTES-1:0][7:0]  bytes;
    } t_cmd;

endpackage

[hw/rtl/jsu_front.sv]
// Front end of the JSON string unescape block: escape and hex decoder.
// Turns each input byte into at most one command for the queue.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_front import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        M_NORMAL,
        M_ESC,
        M_HEX1,
        M_WAIT_BSL,
        M_WAIT_U,
        M_HEX2
    } t_mode;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;
    localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] ONE_BYTE_LIM = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIM = 16'h0800;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // Single plain byte.
    function automatic t_cmd f_one(input logic [7:0] b);
        t_cmd c;
        c = '0;
        c.bytes[0] = b;
        return c;
    endfunction

    // Code point below the supplementary planes, known to be non-zero.
    function automatic t_cmd f_bmp(input logic [15:0] v);
        t_cmd c;
        c = '0;
        if (v < ONE_BYTE_LIM) begin
            c.bytes[0] = v[7:0];
        end else if (v < TWO_BYTE_LIM) begin
            c.bytes[0] = {3'b110, v[10:6]};
            c.bytes[1] = {2'b10, v[5:0]};
            c.last_idx = 2'd1;
        end else begin
            c.bytes[0] = {4'b1110, v[15:12]};
            c.bytes[1] = {2'b10, v[11:6]};
            c.bytes[2] = {2'b10, v[5:0]};
            c.last_idx = 2'd2;
        end
        return c;
    endfunction

    // Supplementary code point, always four bytes.
    function automatic t_cmd f_supp(input logic [20:0] cp);
        t_cmd c;
        c = '0;
        c.bytes[0] = {5'b11110, cp[20:18]};
        c.bytes[1] = {2'b10, cp[17:12]};
        c.bytes[2] = {2'b10, cp[11:6]};
        c.bytes[3] = {2'b10, cp[5:0]};
        c.last_idx = 2'd3;
        return c;
    endfunction

    t_mode       r_mode, n_mode, w_eff;
    logic [15:0] r_hex_value, n_hex_value;
    logic [1:0]  r_digits, n_digits;
    logic        r_bad, n_bad;
    logic [9:0]  r_high, n_high;

    logic        w_accept;
    logic        w_emit;
    logic        w_end;
    t_cmd        w_cmd;
    logic [3:0]  w_digit;
    logic        w_digit_ok;
    logic [15:0] w_hex_acc;
    logic        w_bad_acc;
    logic [15:0] w_val;
    logic [20:0] w_cp;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept && w_emit;
    assign o_cmd    = w_cmd;

    // Hex digit value of the incoming byte.
    always_comb begin
        w_digit    = '0;
        w_digit_ok = 1'b1;
        case (i_byte) inside
            [8'h30:8'h39]: w_digit = i_byte[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: w_digit = i_byte[3:0] + 4'd9;
            default: w_digit_ok = 1'b0;
        endcase
    end

    // Value as it stands once this digit is taken in; a bad digit zeroes it.
    assign w_hex_acc = {r_hex_value[11:0], w_digit};
    assign w_bad_acc = r_bad || !w_digit_ok;
    assign w_val     = w_bad_acc ? 16'h0000 : w_hex_acc;
    assign w_cp      = SUPP_BASE + {1'b0, r_high, w_val[9:0]};

    // Decoder next state and command.
    always_comb begin
        n_mode      = r_mode;
        n_hex_value = r_hex_value;
        n_digits    = r_digits;
        n_bad       = r_bad;
        n_high      = r_high;
        w_emit      = 1'b0;
        w_end       = 1'b0;
        w_cmd       = '0;

        // A pending high surrogate that is not followed by a backslash-u is
        // dropped and the byte is handled as in normal or escape mode.
        w_eff = r_mode;
        if (r_mode == M_WAIT_BSL && i_byte != CH_BSL) begin
            w_eff  = M_NORMAL;
            n_high = '0;
        end
        if (r_mode == M_WAIT_U && i_byte != CH_U) begin
            w_eff  = M_ESC;
            n_high = '0;
        end

        case (w_eff)
            M_ESC: begin
                n_mode = M_NORMAL;
                case (i_byte)
                    CH_NUL: w_end = 1'b1;
                    CH_B: begin
                        w_emit = 1'b1;
                        w_cmd  = f_one(8'h08);
                    end
                    CH_F: begin
                        w_emit = 1'b1;
                        w_cmd  = f_one(8'h0C);
                    end
                    CH_N: begin
                        w_emit = 1'b1;
                        w_cmd  = f_one(8'h0A);
                    end
                    CH_R: begin
                        w_emit = 1'b1;
                        w_cmd  = f_one(8'h0D);
                    end
                    CH_T: begin
                        w_emit = 1'b1;
                        w_cmd  = f_one(8'h09);
                    end
                    CH_U: begin
                        n_mode      = M_HEX1;
                        n_hex_value = '0;
                        n_digits    = '0;
                        n_bad       = 1'b0;
                    end
                    default: begin
                        w_emit = 1'b1;
                        w_cmd  = f_one(i_byte);
                    end
                endcase
            end
            M_HEX1, M_HEX2: begin
                if (i_byte == CH_NUL) begin
                    w_end = 1'b1;
                end else if (r_digits != 2'd3) begin
                    n_digits    = r_digits + 2'd1;
                    n_hex_value = w_hex_acc;
                    n_bad       = w_bad_acc;
                end else begin
                    n_digits    = '0;
                    n_hex_value = '0;
                    n_bad       = 1'b0;
                    n_mode      = M_NORMAL;
                    if (w_eff == M_HEX2) begin
                        n_high = '0;
                        if (w_val >= LOW_SUR_MIN && w_val <= LOW_SUR_MAX) begin
                            w_emit = 1'b1;
                            w_cmd  = f_supp(w_cp);
                        end
                    end else if (w_val == 16'h0000 ||
                                 (w_val >= LOW_SUR_MIN && w_val <= LOW_SUR_MAX)) begin
                        // Zero or a lone low surrogate gives nothing.
                        n_mode = M_NORMAL;
                    end else if (w_val >= HIGH_SUR_MIN && w_val <= HIGH_SUR_MAX) begin
                        n_high = w_val[9:0];
                        n_mode = M_WAIT_BSL;
                    end else begin
                        w_emit = 1'b1;
                        w_cmd  = f_bmp(w_val);
                    end
                end
            end
            M_WAIT_BSL: begin
                n_mode = M_WAIT_U;
            end
            M_WAIT_U: begin
                n_mode      = M_HEX2;
                n_hex_value = '0;
                n_digits    = '0;
                n_bad       = 1'b0;
            end
            default: begin
                n_mode = M_NORMAL;
                if (i_byte == CH_QUOTE || i_byte == CH_NUL) begin
                    w_end = 1'b1;
                end else if (i_byte == CH_BSL) begin
                    n_mode = M_ESC;
                end else begin
                    w_emit = 1'b1;
                    w_cmd  = f_one(i_byte);
                end
            end
        endcase

        // The end of the string returns every register to its reset value.
        if (w_end) begin
            w_emit       = 1'b1;
            w_cmd        = '0;
            w_cmd.is_end = 1'b1;
            n_mode       = M_NORMAL;
            n_hex_value  = '0;
            n_digits     = '0;
            n_bad        = 1'b0;
            n_high       = '0;
        end
    end

    // Decoder state, advanced on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_NORMAL;
            r_hex_value <= '0;
            r_digits    <= '0;
            r_bad       <= 1'b0;
            r_high      <= '0;
        end else if (w_accept) begin
            r_mode      <= n_mode;
            r_hex_value <= n_hex_value;
            r_digits    <= n_digits;
            r_bad       <= n_bad;
            r_high      <= n_high;
        end
    end

endmodule

[hw/rtl/jsu_queue.sv]
// Command queue between the decoder and the output serialiser.
// A small first-in first-out store of commands with a registered fill count.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_queue import jsu_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Storage; written only at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count, wrapping at the depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/jsu_back.sv]
// Back end of the JSON string unescape block: output serialiser.
// Walks the bytes of the head command into a registered output word.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_back import jsu_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_end_marker,
    output logic       o_last
);

    logic [CMD_IDX_W-1:0] r_idx;
    logic                 r_valid;
    logic [7:0]           r_byte;
    logic                 r_end;
    logic                 r_last;
    logic                 w_load;
    logic                 w_final;

    // The output register takes a new word when empty or being taken.
    assign w_load  = !r_valid || i_ready;
    assign w_final = (r_idx == i_q_head.last_idx);
    assign o_pop   = w_load && i_q_valid && w_final;

    assign o_valid      = r_valid;
    assign o_byte       = r_byte;
    assign o_end_marker = r_end;
    assign o_last       = r_last;

    // Control: output valid and the byte index within the head command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= w_final ? '0 : r_idx + 1'b1;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load && i_q_valid) begin
            r_byte <= i_q_head.bytes[r_idx];
            r_end  <= i_q_head.is_end;
            r_last <= w_final;
        end
    end

endmodule

[hw/rtl/json_string_unescape.sv]
// Top level of the JSON string unescape block.
// Joins the decoder, the command queue and the output serialiser.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_byte
//  out     | output    | o_out_valid/i_out_ready | o_out_byte, o_end_marker, o_last
//
// One input word is decoded per cycle whenever the command queue has room.
// Output words leave one per cycle while the receiver is ready; a multi-byte UTF-8
// sequence holds the queue head until its last byte is loaded, so a run of such
// escapes can fill the queue. Input passes through queue and output register.
// Reset is synchronous and active low; it empties the queue and the output.
// Either side may stall; the queue of QUEUE_DEPTH commands parts the two.
`timescale 1ns / 1ps

module json_string_unescape import jsu_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_end_marker,
    output logic       o_last
);

    logic w_push;
    t_cmd w_cmd;
    logic w_q_full;
    logic w_pop;
    logic w_q_valid;
    t_cmd w_q_head;

    // Decoder.
    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_byte  (i_in_byte),
        .i_full  (w_q_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    // Command queue.
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_head  (w_q_head)
    );

    // Output serialiser.
    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_head     (w_q_head),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_byte       (o_out_byte),
        .o_end_marker (o_end_marker),
        .o_last       (o_last)
    );

`ifndef SYNTHESIS
    // An end marker carries no byte and closes its input word.
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_marker |-> o_out_byte == 8'h00 && o_last)
        else $error("end marker word carries a byte or is not last");

    // The serialiser only retires a command that is present.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("command popped from an empty queue");

    // An end command is a single empty word.
    a_end_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_cmd.is_end |-> w_cmd.last_idx == '0 && w_cmd.bytes == '0)
        else $error("end command is not a single empty word");
`endif

endmodule

[tb/json_string_unescape_test.sv]
// Self-checking testbench for the JSON string unescape block.
// Drives string body bytes, predicts the decoded words and checks them in order.
// Depends on json_string_unescape and its package jsu_pkg.
`timescale 1ns / 1ps

module json_string_unescape_test;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_WORDS  = 430;
    localparam int unsigned STEADY_TAIL   = 60;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned MAX_REPORTS   = 40;

    // Characters the decoder reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = "u";
    localparam logic [7:0] CH_B     = "b";
    localparam logic [7:0] CH_F     = "f";
    localparam logic [7:0] CH_N     = "n";
    localparam logic [7:0] CH_R     = "r";
    localparam logic [7:0] CH_T     = "t";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UF    = "F";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LF    = "f";

    // Control characters produced by the short escapes.
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;
    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_HT = 8'h09;

    // UTF-16 surrogate ranges.
    localparam logic [15:0] HI_FIRST = 16'hD800;
    localparam logic [15:0] HI_LAST  = 16'hDBFF;
    localparam logic [15:0] LO_FIRST = 16'hDC00;
    localparam logic [15:0] LO_LAST  = 16'hDFFF;

    typedef enum logic [3:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX1,
        MODE_WAIT_BSL,
        MODE_WAIT_U,
        MODE_HEX2
    } t_dec_mode;

    typedef struct packed {
        logic [7:0] data;
        logic       end_mk;
        logic       last;
    } t_out_word;

    // Predicts the decoded words of each accepted byte and checks the results in order.
    class unescape_scoreboard;
        t_out_word   pending[$];
        t_dec_mode   mode;
        logic [15:0] hex_acc;
        logic [1:0]  n_digits;
        logic        hex_bad;
        logic [9:0]  hi_half;
        int unsigned n_err;
        int unsigned n_in;
        int unsigned n_out;
        int unsigned n_end;
        int unsigned n_quad;

        function new();
            clear_state();
            n_err  = 0;
            n_in   = 0;
            n_out  = 0;
            n_end  = 0;
            n_quad = 0;
        endfunction

        function void clear_state();
            mode     = MODE_PLAIN;
            hex_acc  = 16'h0;
            n_digits = 2'd0;
            hex_bad  = 1'b0;
            hi_half  = 10'h0;
        endfunction

        function void put_byte(input logic [7:0] b);
            t_out_word w;
            w.data   = b;
            w.end_mk = 1'b0;
            w.last   = 1'b0;
            pending.push_back(w);
        endfunction

        // The end marker carries no byte and returns the decoder to its reset state.
        function void put_end();
            t_out_word w;
            w.data   = 8'h00;
            w.end_mk = 1'b1;
            w.last   = 1'b0;
            pending.push_back(w);
            n_end++;
            clear_state();
        endfunction

        function void put_code_point(input logic [20:0] cp);
            if (cp < 21'h80) begin
                put_byte(cp[7:0]);
            end else if (cp < 21'h800) begin
                put_byte({3'b110, cp[10:6]});
                put_byte({2'b10, cp[5:0]});
            end else if (cp < 21'h10000) begin
                put_byte({4'b1110, cp[15:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
            end else begin
                put_byte({5'b11110, cp[20:18]});
                put_byte({2'b10, cp[17:12]});
                put_byte({2'b10, cp[11:6]});
                put_byte({2'b10, cp[5:0]});
                n_quad++;
            end
        endfunction

        function void plain(input logic [7:0] b);
            mode = MODE_PLAIN;
            if (b == CH_QUOTE || b == CH_NUL)
                put_end();
            else if (b == CH_BSL)
                mode = MODE_ESC;
            else
                put_byte(b);
        endfunction

        function void escape(input logic [7:0] b);
            mode = MODE_PLAIN;
            case (b)
                CH_NUL: put_end();
                CH_B:   put_byte(CTL_BS);
                CH_F:   put_byte(CTL_FF);
                CH_N:   put_byte(CTL_LF);
                CH_R:   put_byte(CTL_CR);
                CH_T:   put_byte(CTL_HT);
                CH_U: begin
                    mode     = MODE_HEX1;
                    hex_acc  = 16'h0;
                    n_digits = 2'd0;
                    hex_bad  = 1'b0;
                end
                default: put_byte(b);
            endcase
        endfunction

        // Gathers one digit; a non-hex byte counts as zero and spoils the value.
        function bit take_digit(input logic [7:0] b);
            logic [3:0] d;
            d = 4'h0;
            if (b >= CH_0 && b <= CH_9)
                d = 4'(b - CH_0);
            else if (b >= CH_UA && b <= CH_UF)
                d = 4'(b - CH_UA + 8'd10);
            else if (b >= CH_LA && b <= CH_LF)
                d = 4'(b - CH_LA + 8'd10);
            else
                hex_bad = 1'b1;
            hex_acc = {hex_acc[11:0], d};
            if (n_digits == 2'd3) begin
                n_digits = 2'd0;
                return 1'b1;
            end
            n_digits = n_digits + 2'd1;
            return 1'b0;
        endfunction

        function void hex(input logic [7:0] b, input bit second);
            logic [15:0] v;
            if (b == CH_NUL) begin
                put_end();
                return;
            end
            if (!take_digit(b))
                return;
            v       = hex_bad ? 16'h0 : hex_acc;
            hex_acc = 16'h0;
            hex_bad = 1'b0;
            mode    = MODE_PLAIN;
            if (second) begin
                if (v >= LO_FIRST && v <= LO_LAST)
                    put_code_point(21'h10000 + {hi_half, v[9:0]});
                hi_half = 10'h0;
                return;
            end
            // Zero and a lone low half give nothing; a high half waits for its partner.
            if (v == 16'h0 || (v >= LO_FIRST && v <= LO_LAST))
                return;
            if (v >= HI_FIRST && v <= HI_LAST) begin
                hi_half = v[9:0];
                mode    = MODE_WAIT_BSL;
                return;
            end
            put_code_point({5'd0, v});
        endfunction

        function void note_input(input logic [7:0] b);
            int unsigned before_n;
            t_out_word   w;
            before_n = pending.size();
            n_in++;
            case (mode)
                MODE_ESC:  escape(b);
                MODE_HEX1: hex(b, 1'b0);
                MODE_HEX2: hex(b, 1'b1);
                MODE_WAIT_BSL: begin
                    if (b == CH_BSL) begin
                        mode = MODE_WAIT_U;
                    end else begin
                        hi_half = 10'h0;
                        plain(b);
                    end
                end
                MODE_WAIT_U: begin
                    if (b == CH_U) begin
                        mode     = MODE_HEX2;
                        hex_acc  = 16'h0;
                        n_digits = 2'd0;
                        hex_bad  = 1'b0;
                    end else begin
                        hi_half = 10'h0;
                        escape(b);
                    end
                end
                default: plain(b);
            endcase
            // The final word caused by this byte carries the last flag.
            if (pending.size() > before_n) begin
                w      = pending.pop_back();
                w.last = 1'b1;
                pending.push_back(w);
            end
        endfunction

        task report(input string msg);
            n_err++;
            if (n_err <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endtask

        task check(input logic [7:0] data, input logic end_mk, input logic last);
            t_out_word w;
            n_out++;
            if (pending.size() == 0) begin
                report($sformatf("word %0d arrived with none awaited (byte %02h end %b last %b)",
                                 n_out, data, end_mk, last));
                return;
            end
            w = pending.pop_front();
            if (data !== w.data)
                report($sformatf("word %0d: byte %02h, predicted %02h", n_out, data, w.data));
            if (end_mk !== w.end_mk)
                report($sformatf("word %0d: end marker %b, predicted %b",
                                 n_out, end_mk, w.end_mk));
            if (last !== w.last)
                report($sformatf("word %0d: last %b, predicted %b", n_out, last, w.last));
        endtask
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_in_byte    = 8'h00;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_end_marker;
    logic       o_last;

    unescape_scoreboard sb;
    logic        steady_phase   = 1'b0;
    int unsigned cycle_count    = 0;
    int unsigned n_sent         = 0;
    int unsigned in_calm_left   = 0;
    int unsigned out_stall_left = 0;
    int unsigned out_calm_left  = 0;
    int unsigned out_pick;

    json_string_unescape u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_end_marker (o_end_marker),
        .o_last       (o_last)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Watchdog on the overall run length.
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d words outstanding.",
                     cycle_count, sb.pending.size());
            $display("json_string_unescape: mismatch");
            $finish;
        end
    end

    // Both handshakes are sampled at the edge, before the block updates.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_input(i_in_byte);
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check(o_out_byte, o_end_marker, o_last);
    end

    // Receiver back-pressure: random stall bursts, calm stretches, none at the end.
    always @(posedge i_clk) begin
        if (out_stall_left != 0) begin
            out_stall_left <= out_stall_left - 1;
            i_out_ready    <= 1'b0;
        end else if (steady_phase || out_calm_left != 0) begin
            if (out_calm_left != 0)
                out_calm_left <= out_calm_left - 1;
            i_out_ready <= 1'b1;
        end else begin
            out_pick = $urandom_range(0, 9);
            if (out_pick < 3) begin
                out_stall_left <= $urandom_range(0, 11);
                i_out_ready    <= 1'b0;
            end else if (out_pick == 3) begin
                out_calm_left <= $urandom_range(20, 80);
                i_out_ready   <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic bit is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
               (c >= CH_LA && c <= CH_LF);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CH_0 + nib;
        return (($urandom_range(0, 1) == 1) ? CH_UA : CH_LA) + nib - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_hex(c));
        return c;
    endfunction

    // Offers one word, with an occasional idle burst before it, and waits for acceptance.
    task automatic send_word(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (!steady_phase) begin
            if (in_calm_left != 0)
                in_calm_left--;
            else if ($urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 12);
            else if ($urandom_range(0, 19) == 0)
                in_calm_left = $urandom_range(15, 60);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // Holds the sender off until every predicted word has come out.
    task automatic drain_all();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    // A u escape with four digits; spoil puts one non-hex byte among them.
    task automatic send_unicode(input logic [15:0] cp, input bit spoil);
        int unsigned bad_at;
        bad_at = $urandom_range(0, 3);
        send_word(CH_BSL);
        send_word(CH_U);
        for (int i = 3; i >= 0; i--)
            send_word((spoil && i == bad_at) ? non_hex_byte() : hex_char(cp[i*4 +: 4]));
    endtask

    function automatic logic [15:0] rand_high();
        return 16'($urandom_range(HI_FIRST, HI_LAST));
    endfunction

    // An escape cut short by NUL at some point, which ends the string.
    task automatic send_cut_escape();
        int unsigned where;
        int unsigned ndig;
        where = $urandom_range(0, 3);
        ndig  = $urandom_range(0, 3);
        if (where >= 2)
            send_unicode(rand_high(), 1'b0);
        send_word(CH_BSL);
        if (where == 1 || where == 3) begin
            send_word(CH_U);
            for (int i = 0; i < ndig; i++)
                send_word(hex_char(4'($urandom_range(0, 15))));
        end
        send_word(CH_NUL);
    endtask

    // One random piece of a string body, mostly well formed.
    task automatic send_token();
        int unsigned tok;
        int unsigned k;
        logic [7:0]  c;
        tok = $urandom_range(0, 99);
        if (tok < 28) begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSL);
            send_word(c);
        end else if (tok < 42) begin
            send_word(CH_BSL);
            k = $urandom_range(0, 7);
            case (k)
                0: c = CH_B;
                1: c = CH_F;
                2: c = CH_N;
                3: c = CH_R;
                4: c = CH_T;
                5: c = CH_QUOTE;
                6: c = CH_BSL;
                default: do c = 8'($urandom_range(1, 255)); while (c == CH_U);
            endcase
            send_word(c);
        end else if (tok < 64) begin
            k = $urandom_range(0, 6);
            case (k)
                0: send_unicode(16'($urandom_range(16'h0001, 16'h007F)), 1'b0);
                1: send_unicode(16'($urandom_range(16'h0080, 16'h07FF)), 1'b0);
                2: send_unicode(16'($urandom_range(16'h0800, 16'hD7FF)), 1'b0);
                3: send_unicode(16'($urandom_range(16'hE000, 16'hFFFF)), 1'b0);
                4: send_unicode(16'h0000, 1'b0);
                5: send_unicode(16'($urandom_range(LO_FIRST, LO_LAST)), 1'b0);
                default: send_unicode(16'($urandom_range(0, 16'hFFFF)), 1'b1);
            endcase
        end else if (tok < 80) begin
            // Surrogate pair, sometimes with a wrong or spoiled second half.
            send_unicode(rand_high(), 1'b0);
            k = $urandom_range(0, 5);
            if (k == 0)
                send_unicode(16'($urandom_range(0, 16'hFFFF)), 1'b0);
            else if (k == 1)
                send_unicode(16'($urandom_range(LO_FIRST, LO_LAST)), 1'b1);
            else
                send_unicode(16'($urandom_range(LO_FIRST, LO_LAST)), 1'b0);
        end else if (tok < 86) begin
            // High half followed by anything but a backslash.
            send_unicode(rand_high(), 1'b0);
            do c = 8'($urandom_range(0, 255)); while (c == CH_BSL);
            send_word(c);
        end else if (tok < 91) begin
            // High half, then a backslash starting some other escape.
            send_unicode(rand_high(), 1'b0);
            send_word(CH_BSL);
            do c = 8'($urandom_range(1, 255)); while (c == CH_U);
            send_word(($urandom_range(0, 1) == 1) ? CH_N : c);
        end else if (tok < 95) begin
            send_word(($urandom_range(0, 1) == 1) ? CH_QUOTE : CH_NUL);
        end else if (tok < 97) begin
            send_cut_escape();
        end else begin
            k = $urandom_range(1, 8);
            repeat (k) send_word(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0]  lead_in[$];
        int unsigned target;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Byte extremes, short and other escapes, largest 3-byte and 4-byte code points.
        lead_in = '{8'h01, 8'hFF, CH_BSL, CH_N, CH_BSL, "z",
                    CH_BSL, CH_U, "F", "f", "F", "f",
                    CH_BSL, CH_U, "D", "B", "F", "F", CH_BSL, CH_U, "D", "F", "F", "F",
                    CH_QUOTE};
        foreach (lead_in[i])
            send_word(lead_in[i]);
        drain_all();

        target = n_sent + RANDOM_WORDS;
        while (n_sent < target) begin
            if (!steady_phase && n_sent + STEADY_TAIL >= target)
                steady_phase <= 1'b1;
            send_token();
            if (!steady_phase && $urandom_range(0, 59) == 0)
                drain_all();
        end
        drain_all();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d input words and checked %0d output words in %0d cycles.",
                 sb.n_in, sb.n_out, cycle_count);
        $display("The run saw %0d string ends and %0d four-byte UTF-8 sequences.",
                 sb.n_end, sb.n_quad);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("json_string_unescape: match");
        end else begin
            $display("%0d mismatches, %0d words never arrived.", sb.n_err, sb.pending.size());
            $display("json_string_unescape: mismatch");
        end
        $finish;
    end

endmodule
